// ===== design/nswp_pkg.sv =====
package nswp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_STEPS_DEF = 16;
    localparam int COEF_BITS_DEF = 16;

    // Fixed field widths.
    localparam int PHASE_BITS      = 16;
    localparam int SAMPLE_BITS     = 8;
    localparam int STEP_COUNT_BITS = 5;
    localparam logic [STEP_COUNT_BITS-1:0] STEP_COUNT_RESET = 5'd4;

    // Queue between the accumulator and the CORDIC unit.
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

    // CORDIC: angles are kept in units of 2^-32 turn.
    localparam int CORDIC_ITERS   = 30;
    localparam int TURN_BITS      = 32;
    localparam int PRESCALE_SHIFT = 20;

    // Fixed-point constants used to build the tables.
    localparam int    TAYLOR_TERMS = 9;
    localparam longint Q30_ONE     = 64'sd1 <<< 30;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 2 * PI_Q30;

    // Width of the signed sine and cosine sums.
    function automatic int sum_width(int max_steps, int coef_bits);
        return coef_bits + SAMPLE_BITS + 1 + $clog2(max_steps);
    endfunction

    function automatic longint div_sin_den(longint v, int m);
        case (m)
            1:       return v / 6;
            2:       return v / 20;
            3:       return v / 42;
            4:       return v / 72;
            5:       return v / 110;
            6:       return v / 156;
            7:       return v / 210;
            8:       return v / 272;
            9:       return v / 342;
            default: return v;
        endcase
    endfunction

    function automatic longint div_cos_den(longint v, int m);
        case (m)
            1:       return v / 2;
            2:       return v / 12;
            3:       return v / 30;
            4:       return v / 56;
            5:       return v / 90;
            6:       return v / 132;
            7:       return v / 182;
            8:       return v / 240;
            9:       return v / 306;
            default: return v;
        endcase
    endfunction

    // Divides by the odd number 2n+1 of the arctangent series.
    function automatic longint unsigned div_odd(longint unsigned v, int n);
        case (n)
            0:       return v;
            1:       return v / 3;
            2:       return v / 5;
            3:       return v / 7;
            4:       return v / 9;
            5:       return v / 11;
            6:       return v / 13;
            7:       return v / 15;
            8:       return v / 17;
            9:       return v / 19;
            10:      return v / 21;
            11:      return v / 23;
            12:      return v / 25;
            13:      return v / 27;
            14:      return v / 29;
            15:      return v / 31;
            16:      return v / 33;
            17:      return v / 35;
            18:      return v / 37;
            19:      return v / 39;
            20:      return v / 41;
            21:      return v / 43;
            22:      return v / 45;
            23:      return v / 47;
            24:      return v / 49;
            25:      return v / 51;
            26:      return v / 53;
            27:      return v / 55;
            28:      return v / 57;
            29:      return v / 59;
            30:      return v / 61;
            default: return 64'd0;
        endcase
    endfunction

    // Sine or cosine of a residual angle r (Q30 radians, below pi/2) by Horner-form Taylor series.
    function automatic longint trig_q30(longint r, bit want_cos);
        longint x2;
        longint ts;
        longint tc;
        x2 = (r * r) / Q30_ONE;
        ts = Q30_ONE;
        tc = Q30_ONE;
        for (int m = TAYLOR_TERMS; m >= 1; m--) begin
            ts = Q30_ONE - div_sin_den((x2 * ts) / Q30_ONE, m);
            tc = Q30_ONE - div_cos_den((x2 * tc) / Q30_ONE, m);
        end
        return want_cos ? tc : (r * ts) / Q30_ONE;
    endfunction

    // Q30 to a coefficient with coef_bits-1 fraction bits, rounded half up and saturated.
    function automatic longint q30_to_coef(longint v, int coef_bits);
        int     sh;
        longint maxv;
        longint q;
        sh   = 31 - coef_bits;
        maxv = (64'sd1 <<< (coef_bits - 1)) - 1;
        q    = (v < 0) ? 64'sd0 : v;
        q    = (q + (64'sd1 <<< (sh - 1))) >>> sh;
        return (q > maxv) ? maxv : q;
    endfunction

    // Coefficient for quadrant quad and residual angle r.
    function automatic longint coef_value(int quad, longint r, int coef_bits, bit want_cos);
        longint s0;
        longint c0;
        longint sn;
        longint cs;
        s0 = q30_to_coef(trig_q30(r, 1'b0), coef_bits);
        c0 = q30_to_coef(trig_q30(r, 1'b1), coef_bits);
        case (quad)
            0: begin
                sn = s0;
                cs = c0;
            end
            1: begin
                sn = c0;
                cs = -s0;
            end
            2: begin
                sn = -s0;
                cs = -c0;
            end
            default: begin
                sn = -c0;
                cs = s0;
            end
        endcase
        return want_cos ? cs : sn;
    endfunction

    // atan(2^-i) as a fraction of a turn, scaled by 2^32.
    function automatic logic [TURN_BITS-1:0] atan_turn_entry(int i);
        longint unsigned acc;
        longint unsigned term;
        int              e;
        acc = 64'd0;
        if (i == 0) begin
            return 32'h2000_0000;
        end
        for (int n = 0; n <= 30; n++) begin
            e = i * (2 * n + 1);
            if (e < 62) begin
                term = div_odd(64'd1 << (62 - e), n);
                acc  = (n % 2 == 1) ? acc - term : acc + term;
            end
        end
        return TURN_BITS'((acc + PI_Q30) / TWO_PI_Q30);
    endfunction

endpackage

// ===== design/nswp_front.sv =====
module nswp_front
    import nswp_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF,
    localparam int SUM_BITS = sum_width(MAX_STEPS, COEF_BITS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [STEP_COUNT_BITS-1:0] cfg_step_count,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_sample,
    input  logic [LEVEL_BITS-1:0]      fifo_level,
    output logic                       push_valid,
    output logic signed [SUM_BITS-1:0] push_cos,
    output logic signed [SUM_BITS-1:0] push_sin
);

    localparam int IDX_BITS  = $clog2(MAX_STEPS);
    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS + 1;

    logic signed [COEF_BITS-1:0] sin_rom [MAX_STEPS][MAX_STEPS];
    logic signed [COEF_BITS-1:0] cos_rom [MAX_STEPS][MAX_STEPS];

    // Coefficient table, indexed by step and by N-1. Built at elaboration.
    for (genvar K = 0; K < MAX_STEPS; K++) begin : g_rom_row
        for (genvar NI = 0; NI < MAX_STEPS; NI++) begin : g_rom_col
            localparam int     NV    = NI + 1;
            localparam int     QUAD  = ((4 * K) / NV) % 4;
            localparam int     REM   = (4 * K) % NV;
            localparam longint R_Q30 = (PI_Q30 * REM) / (2 * NV);
            localparam longint SIN_V = coef_value(QUAD, R_Q30, COEF_BITS, 1'b0);
            localparam longint COS_V = coef_value(QUAD, R_Q30, COEF_BITS, 1'b1);
            assign sin_rom[K][NI] = COEF_BITS'(SIN_V);
            assign cos_rom[K][NI] = COEF_BITS'(COS_V);
        end
    end

    logic [STEP_COUNT_BITS-1:0] step_count_reg;
    logic [IDX_BITS-1:0]        step_index_reg, step_index_next;
    logic [IDX_BITS-1:0]        n_idx;
    logic                       accept, last;

    logic                        s1_valid_reg, s1_last_reg;
    logic [SAMPLE_BITS-1:0]      s1_sample_reg;
    logic signed [COEF_BITS-1:0] s1_sin_reg, s1_cos_reg;

    logic                        s2_valid_reg, s2_last_reg;
    logic signed [PROD_BITS-1:0] s2_sin_prod_reg, s2_cos_prod_reg;
    logic signed [PROD_BITS-1:0] sin_prod, cos_prod;

    logic signed [SUM_BITS-1:0] sin_sum_reg, cos_sum_reg;
    logic signed [SUM_BITS-1:0] sin_sum_next, cos_sum_next;
    logic signed [SUM_BITS-1:0] sin_sum_add, cos_sum_add;

    logic [1:0]            inflight;
    logic [LEVEL_BITS:0]   committed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_COUNT_RESET;
        end else if (cfg_valid) begin
            step_count_reg <= cfg_step_count;
        end
    end

    // A step count of zero acts as one, and one above MAX_STEPS as MAX_STEPS.
    always_comb begin
        if (step_count_reg == '0) begin
            n_idx = '0;
        end else if (int'(step_count_reg) > MAX_STEPS) begin
            n_idx = IDX_BITS'(MAX_STEPS - 1);
        end else begin
            n_idx = IDX_BITS'(step_count_reg - 1'b1);
        end
    end

    // Each pixel that ends in the pipeline holds a queue slot in advance.
    assign inflight  = {1'b0, s1_valid_reg & s1_last_reg} + {1'b0, s2_valid_reg & s2_last_reg};
    assign committed = (LEVEL_BITS + 1)'(fifo_level) + (LEVEL_BITS + 1)'(inflight);
    assign s_ready   = committed < (LEVEL_BITS + 1)'(QUEUE_DEPTH);

    assign accept          = s_valid & s_ready;
    assign last            = step_index_reg >= n_idx;
    assign step_index_next = last ? '0 : step_index_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_index_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                step_index_reg <= step_index_next;
                s1_last_reg    <= last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= s_sample;
            s1_sin_reg    <= sin_rom[step_index_reg][n_idx];
            s1_cos_reg    <= cos_rom[step_index_reg][n_idx];
        end
    end

    assign sin_prod = $signed({1'b0, s1_sample_reg}) * s1_sin_reg;
    assign cos_prod = $signed({1'b0, s1_sample_reg}) * s1_cos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_sin_prod_reg <= sin_prod;
            s2_cos_prod_reg <= cos_prod;
        end
    end

    assign sin_sum_add = sin_sum_reg + SUM_BITS'(s2_sin_prod_reg);
    assign cos_sum_add = cos_sum_reg + SUM_BITS'(s2_cos_prod_reg);

    always_comb begin
        sin_sum_next = sin_sum_reg;
        cos_sum_next = cos_sum_reg;
        if (s2_valid_reg) begin
            sin_sum_next = s2_last_reg ? '0 : sin_sum_add;
            cos_sum_next = s2_last_reg ? '0 : cos_sum_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sin_sum_reg <= '0;
            cos_sum_reg <= '0;
        end else begin
            sin_sum_reg <= sin_sum_next;
            cos_sum_reg <= cos_sum_next;
        end
    end

    assign push_valid = s2_valid_reg & s2_last_reg;
    assign push_sin   = sin_sum_add;
    assign push_cos   = cos_sum_add;

endmodule

// ===== design/nswp_fifo.sv =====
module nswp_fifo
    import nswp_pkg::*;
#(
    parameter int WIDTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head_data,
    output logic [LEVEL_BITS-1:0] level,
    output logic                  not_empty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]      entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign not_empty = level_reg != '0;

endmodule

// ===== design/nswp_cordic.sv =====
module nswp_cordic
    import nswp_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF,
    localparam int SUM_BITS = sum_width(MAX_STEPS, COEF_BITS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  logic signed [SUM_BITS-1:0] head_cos,
    input  logic signed [SUM_BITS-1:0] head_sin,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [PHASE_BITS-1:0]      m_phase
);

    // Room for the sign, the prescale and the CORDIC gain.
    localparam int XY_BITS   = SUM_BITS + PRESCALE_SHIFT + 3;
    localparam int ITER_BITS = $clog2(CORDIC_ITERS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROTATE = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    logic [TURN_BITS-1:0] atan_rom [CORDIC_ITERS];

    for (genvar I = 0; I < CORDIC_ITERS; I++) begin : g_atan
        localparam logic [TURN_BITS-1:0] ATAN_V = atan_turn_entry(I);
        assign atan_rom[I] = ATAN_V;
    end

    state_t                      state_reg, state_next;
    logic [ITER_BITS-1:0]        iter_reg, iter_next;
    logic signed [XY_BITS-1:0]   x_reg, x_next;
    logic signed [XY_BITS-1:0]   y_reg, y_next;
    logic [TURN_BITS-1:0]        z_reg, z_next;
    logic                        zero_reg, zero_next;
    logic                        m_valid_reg, m_valid_next;
    logic [PHASE_BITS-1:0]       m_phase_reg, m_phase_next;

    logic signed [XY_BITS-1:0]   cos_ext, sin_ext, dx, dy;
    logic                        cos_neg, y_pos, out_free;
    logic [TURN_BITS-1:0]        z_round;

    assign cos_ext = XY_BITS'(head_cos) <<< PRESCALE_SHIFT;
    assign sin_ext = XY_BITS'(head_sin) <<< PRESCALE_SHIFT;
    assign cos_neg = head_cos[SUM_BITS-1];

    assign dx    = y_reg >>> iter_reg;
    assign dy    = x_reg >>> iter_reg;
    assign y_pos = !y_reg[XY_BITS-1] && (y_reg != '0);

    assign z_round  = z_reg + (TURN_BITS'(1) << (TURN_BITS - 1 - PHASE_BITS));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_phase_next = m_phase_reg;
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop = 1'b1;
                    // The vector is (cos_sum, -sin_sum); a left half-plane vector is
                    // turned by half a turn first.
                    x_next     = cos_neg ? -cos_ext : cos_ext;
                    y_next     = cos_neg ? sin_ext : -sin_ext;
                    z_next     = cos_neg ? (TURN_BITS'(1) << (TURN_BITS - 1)) : '0;
                    zero_next  = (head_cos == '0) && (head_sin == '0);
                    iter_next  = '0;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                if (y_pos) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_rom[iter_reg];
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_rom[iter_reg];
                end
                iter_next = iter_reg + 1'b1;
                if (int'(iter_reg) == CORDIC_ITERS - 1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_phase_next = zero_reg ? '0 : z_round[TURN_BITS-1 -: PHASE_BITS];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zero_reg    <= zero_next;
        m_phase_reg <= m_phase_next;
    end

    assign m_valid = m_valid_reg;
    assign m_phase = m_phase_reg;

endmodule

// ===== design/n_step_wrapped_phase.sv =====
// Channel  Dir  Ports                                       One word
// s_       in   s_valid, s_ready, s_sample[7:0]             gray sample k of a pixel
// m_       out  m_valid, m_ready, m_phase[15:0]             phase of a pixel, 1/65536 turn
// cfg_     in   cfg_valid, cfg_ready, cfg_step_count[4:0]   samples per pixel N
//
// Samples enter at one per cycle while the four-entry pixel queue has room; cfg_ready is
// always high. Each pixel then holds the CORDIC unit for one load, 30 rotations and one
// handoff to the output register, and the unit takes no new pixel until that handoff.
// m_valid rises after the last sample has passed the s1 and s2 front registers, the queue
// and the CORDIC unit.
// aresetn is synchronous and active low; the step count resets to 4. A stalled m_ready fills
// the output register and then the queue, after which s_ready drops.
module n_step_wrapped_phase
    import nswp_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [STEP_COUNT_BITS-1:0] cfg_step_count,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [SAMPLE_BITS-1:0]     s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [PHASE_BITS-1:0]      m_phase
);

    localparam int SUM_BITS = sum_width(MAX_STEPS, COEF_BITS);

    logic                       push_valid;
    logic signed [SUM_BITS-1:0] push_cos, push_sin;
    logic [2*SUM_BITS-1:0]      head_data;
    logic [LEVEL_BITS-1:0]      fifo_level;
    logic                       fifo_not_empty;
    logic                       fifo_pop;

    nswp_front #(
        .MAX_STEPS (MAX_STEPS),
        .COEF_BITS (COEF_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_step_count (cfg_step_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .fifo_level     (fifo_level),
        .push_valid     (push_valid),
        .push_cos       (push_cos),
        .push_sin       (push_sin)
    );

    nswp_fifo #(
        .WIDTH (2 * SUM_BITS)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data ({push_cos, push_sin}),
        .pop       (fifo_pop),
        .head_data (head_data),
        .level     (fifo_level),
        .not_empty (fifo_not_empty)
    );

    nswp_cordic #(
        .MAX_STEPS (MAX_STEPS),
        .COEF_BITS (COEF_BITS)
    ) u_cordic (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (fifo_not_empty),
        .head_cos   ($signed(head_data[2*SUM_BITS-1:SUM_BITS])),
        .head_sin   ($signed(head_data[SUM_BITS-1:0])),
        .pop        (fifo_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_phase    (m_phase)
    );

    // The slot reservation must keep a finished pixel from meeting a full queue.
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (fifo_level != LEVEL_BITS'(QUEUE_DEPTH)))
        else $error("pixel sums pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> (fifo_level != '0))
        else $error("CORDIC unit popped an empty queue");

    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_level == LEVEL_BITS'(QUEUE_DEPTH)) |-> !s_ready)
        else $error("input ready while the pixel queue is full");

endmodule
